// ----- hw/rtl/ris_pkg.sv -----
// Package for the RGB image scaler: payload structs, register indexes
// and default sizes. No dependencies.
package ris_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int STEP_W     = 24;
    localparam int SIZE_W     = 9;
    localparam int OUT_POS_W  = 12;
    localparam int PROD_W     = STEP_W + OUT_POS_W;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int NUM_LANES  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_COL_STEP   = 3'd2,
        REG_ROW_STEP   = 3'd3,
        REG_BILINEAR   = 3'd4
    } cfg_reg_t;

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [7:0]           src_row;
        logic [7:0]           src_col;
        logic [CHAN_W-1:0]    red_in;
        logic [CHAN_W-1:0]    green_in;
        logic [CHAN_W-1:0]    blue_in;
        logic [OUT_POS_W-1:0] out_row;
        logic [OUT_POS_W-1:0] out_col;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
    } out_item_t;

endpackage

// ----- hw/rtl/rgb_image_scaler_nearest_bilinear_core.sv -----
// Top level of the RGB image scaler: position pipeline, four frame store
// banks, four weighting lanes and a merge stage. Uses ris_pkg, ris_ram, ris_lane.
//
//  channel   | valid     | stall     | payload
//  in        | in_valid  | in_stall  | in_data  (in_item_t)
//  out       | out_valid | out_stall | out_data (out_item_t)
//  config    | cfg_we    | -         | cfg_index, cfg_data
//
// One item per cycle when out is not stalled; a request result passes
// through the position multiply, store read, two lane multiplies and the
// merge register. A write is registered in we_reg before it reaches the
// store. A stall on out freezes the whole pipeline; in_stall is the out
// stall while the last stage holds a result. Reset clears the valid
// pipeline, the write enable and the config registers; the frame store has no reset.
module rgb_image_scaler_nearest_bilinear_core
    import ris_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int IW    = PROD_W - FRAC_BITS + 1;
    localparam int TW    = 2 * FRAC_BITS + CHAN_W + 2;
    localparam int DEPTH = 1 << AW;
    localparam int LAT   = 5;

    // config registers
    logic [SIZE_W-1:0] src_width_reg, src_height_reg;
    logic [STEP_W-1:0] col_step_reg, row_step_reg;
    logic              bilinear_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg     <= SIZE_W'(256);
            src_height_reg    <= SIZE_W'(256);
            col_step_reg      <= STEP_W'(1) << FRAC_BITS;
            row_step_reg      <= STEP_W'(1) << FRAC_BITS;
            bilinear_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg     <= cfg_data[SIZE_W-1:0];
                REG_SRC_HEIGHT: src_height_reg    <= cfg_data[SIZE_W-1:0];
                REG_COL_STEP:   col_step_reg      <= cfg_data[STEP_W-1:0];
                REG_ROW_STEP:   row_step_reg      <= cfg_data[STEP_W-1:0];
                REG_BILINEAR:   bilinear_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped sizes minus one
    logic [12:0] wm1, hm1;
    always_comb
    begin
        if (src_width_reg < SIZE_W'(2))
            wm1 = 13'd1;
        else if (32'(src_width_reg) > MAX_WIDTH)
            wm1 = 13'(MAX_WIDTH - 1);
        else
            wm1 = 13'(src_width_reg) - 13'd1;
        if (src_height_reg < SIZE_W'(2))
            hm1 = 13'd1;
        else if (32'(src_height_reg) > MAX_HEIGHT)
            hm1 = 13'(MAX_HEIGHT - 1);
        else
            hm1 = 13'(src_height_reg) - 13'd1;
    end

    logic advance;
    logic [LAT-1:0] vld_reg;
    assign advance  = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !advance;

    logic in_xfer;
    assign in_xfer = in_valid && advance;

    // stage 0: write path and position multiply
    logic              we_reg;
    logic [AW-1:0]     waddr_reg;
    logic [PIX_W-1:0]  wdata_reg;
    logic [PROD_W-1:0] px_reg, py_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_reg <= PROD_W'(col_step_reg * in_data.out_col);
            py_reg <= PROD_W'(row_step_reg * in_data.out_row);
        end
        waddr_reg <= {YW'(in_data.src_row), XW'(in_data.src_col)};
        wdata_reg <= {in_data.red_in, in_data.green_in, in_data.blue_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            we_reg  <= 1'b0;
            vld_reg <= '0;
        end
        else
        begin
            we_reg <= in_xfer && in_data.kind == KIND_WRITE
                      && 32'(in_data.src_row) < MAX_HEIGHT
                      && 32'(in_data.src_col) < MAX_WIDTH;
            if (advance)
            begin
                vld_reg <= {vld_reg[LAT-2:0],
                            in_xfer && in_data.kind == KIND_REQUEST};
            end
        end
    end

    // stage 1: integer positions, neighbours and weights
    logic [IW-1:0]      ix, iy;
    logic [FRAC_BITS-1:0] fx, fy;
    logic [12:0]        x0, y0, x1, y1;
    always_comb
    begin
        fx = px_reg[FRAC_BITS-1:0];
        fy = py_reg[FRAC_BITS-1:0];
        ix = IW'(px_reg[PROD_W-1:FRAC_BITS]);
        iy = IW'(py_reg[PROD_W-1:FRAC_BITS]);
        if (!bilinear_mode_reg)
        begin
            ix = ix + IW'(fx != '0);
            iy = iy + IW'(fy != '0);
        end
        x0 = (ix > IW'(wm1)) ? wm1 : 13'(ix);
        y0 = (iy > IW'(hm1)) ? hm1 : 13'(iy);
        x1 = (x0 < wm1) ? x0 + 13'd1 : wm1;
        y1 = (y0 < hm1) ? y0 + 13'd1 : hm1;
    end

    logic [FRAC_BITS:0] wx0_reg, wx1_reg, wy0_reg, wy1_reg;
    logic [AW-1:0]      raddr [NUM_LANES];
    logic               nearest_reg;

    always_comb
    begin
        raddr[0] = {YW'(y0), XW'(x0)};
        raddr[1] = {YW'(y0), XW'(x1)};
        raddr[2] = {YW'(y1), XW'(x0)};
        raddr[3] = {YW'(y1), XW'(x1)};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // nearest mode uses lane 0 alone with full weight
            wx1_reg <= bilinear_mode_reg ? {1'b0, fx} : '0;
            wy1_reg <= bilinear_mode_reg ? {1'b0, fy} : '0;
            wx0_reg <= ((FRAC_BITS+1)'(1) << FRAC_BITS)
                       - (bilinear_mode_reg ? {1'b0, fx} : '0);
            wy0_reg <= ((FRAC_BITS+1)'(1) << FRAC_BITS)
                       - (bilinear_mode_reg ? {1'b0, fy} : '0);
            nearest_reg <= !bilinear_mode_reg;
        end
    end

    // stage 2: four banks, each a full copy for independent read ports.
    // Read data holds on stall.
    logic [PIX_W-1:0] rdata [NUM_LANES];
    logic [FRAC_BITS:0] wxl [NUM_LANES];
    logic [FRAC_BITS:0] wyl [NUM_LANES];
    logic [TW-1:0]    term [NUM_LANES][3];

    always_comb
    begin
        wxl[0] = wx0_reg; wyl[0] = wy0_reg;
        wxl[1] = wx1_reg; wyl[1] = wy0_reg;
        wxl[2] = wx0_reg; wyl[2] = wy1_reg;
        wxl[3] = wx1_reg; wyl[3] = wy1_reg;
    end

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        ris_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_bank (
            .clk   (clk),
            .we    (we_reg),
            .waddr (waddr_reg),
            .wdata (wdata_reg),
            .re    (advance),
            .raddr (raddr[l]),
            .rdata (rdata[l])
        );

        ris_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clk  (clk),
            .en   (advance),
            .pix  (rdata[l]),
            .wx   (wxl[l]),
            .wy   (wyl[l]),
            .term (term[l])
        );
    end

    // merge: sum the four lane terms, drop fraction, saturate
    out_item_t out_reg;
    logic [TW+1:0] acc [3];
    logic [CHAN_W-1:0] chan [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc[k] = (TW+2)'(term[0][k]) + (TW+2)'(term[1][k])
                   + (TW+2)'(term[2][k]) + (TW+2)'(term[3][k]);
            chan[k] = (acc[k][TW+1:2*FRAC_BITS] > (TW+2-2*FRAC_BITS)'(255))
                      ? 8'hFF : acc[k][2*FRAC_BITS +: CHAN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= '{red_out: chan[0], green_out: chan[1], blue_out: chan[2]};
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_data  = out_reg;

    // a stalled result must not be dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result lost under stall");

    // a request transfer shows up in the pipeline next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_data.kind == KIND_REQUEST |=> vld_reg[0])
        else $error("request not tracked");

    // no store write on a request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_data.kind == KIND_REQUEST |=> !we_reg)
        else $error("spurious store write");

    // nearest mode leaves only lane 0 with weight
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && vld_reg[0] && nearest_reg |=> wx1_reg == '0 && wy1_reg == '0)
        else $error("nearest weights wrong");

endmodule

// ----- hw/rtl/ris_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ris_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // hold read data while re is low
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ris_lane.sv -----
// One bilinear lane: weights one neighbour pixel by its two fractions.
// Pipelined, with one multiply per stage. Uses ris_pkg.
module ris_lane
    import ris_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [PIX_W-1:0]     pix,
    input  logic [FRAC_BITS:0]   wx,
    input  logic [FRAC_BITS:0]   wy,
    output logic [2*FRAC_BITS+CHAN_W+1:0] term [3]
);

    localparam int WW = 2 * FRAC_BITS + 2;

    logic [WW-1:0]              wxy_reg;
    logic [PIX_W-1:0]           pix_reg;
    logic [2*FRAC_BITS+CHAN_W+1:0] term_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wxy_reg <= WW'(wx * wy);
            pix_reg <= pix;
            for (int k = 0; k < 3; k++)
            begin
                term_reg[k] <= (WW+CHAN_W)'(wxy_reg *
                               pix_reg[PIX_W-1-CHAN_W*k -: CHAN_W]);
            end
        end
    end

    assign term = term_reg;

endmodule
